// ===== design/pli_pkg.sv =====
// shared types, constants and state codes for the piecewise linear table interpolator
package pli_pkg;

    localparam int MAX_POINTS = 256;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int DIVC_W     = $clog2(DIV_STEPS);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_POINT_COUNT = 1'b0;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [2:0] ST_INTERP  = 3'd0;
    localparam logic [2:0] ST_PAST    = 3'd1;
    localparam logic [2:0] ST_EQUAL_X = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_SAT     = 3'd4;

    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic                     req_type;
        logic [7:0]               point_index;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] query_position;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] interp_value;
        logic [2:0]               status;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_LD_HI,
        S_LD_LO,
        S_CAP_LO,
        S_DIFF,
        S_MUL,
        S_DIV,
        S_FIN,
        S_PAST_RD,
        S_PAST_WAIT,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        ASEL_SCAN,
        ASEL_HI,
        ASEL_LO,
        ASEL_LAST
    } t_asel;

    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_EMPTY,
        FIN_PAST,
        FIN_EQX,
        FIN_CALC
    } t_fin;

    typedef struct packed {
        logic  start;
        logic  wr;
        logic  scan;
        logic  cap_hi;
        logic  cap_lo;
        logic  diff;
        logic  mul;
        logic  div_step;
        logic  emit;
        t_asel asel;
        t_fin  fin;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic found;
        logic more;
        logic eqx;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

// ===== design/pli_ram.sv =====
// generic single write port, single read port ram with registered read
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pli_ctrl.sv =====
// sequencing state machine for table scan, load, multiply, divide and result
module pli_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_type,
    input  pli_pkg::t_stat i_stat,
    output pli_pkg::t_cmd  o_cmd,
    output logic          o_req_stall
);

    pli_pkg::t_state r_state;
    pli_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pli_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pli_pkg::S_IDLE: begin
                if (i_req_valid && i_req_type == pli_pkg::REQ_QUERY) begin
                    n_state = pli_pkg::S_SCAN;
                end
            end
            pli_pkg::S_SCAN: begin
                if (i_stat.n_zero) begin
                    n_state = pli_pkg::S_EMIT;
                end else if (i_stat.found) begin
                    n_state = pli_pkg::S_LD_HI;
                end else if (!i_stat.more) begin
                    n_state = pli_pkg::S_PAST_RD;
                end
            end
            pli_pkg::S_LD_HI:     n_state = pli_pkg::S_LD_LO;
            pli_pkg::S_LD_LO:     n_state = pli_pkg::S_CAP_LO;
            pli_pkg::S_CAP_LO:    n_state = pli_pkg::S_DIFF;
            pli_pkg::S_DIFF:      n_state = pli_pkg::S_MUL;
            pli_pkg::S_MUL: begin
                if (i_stat.eqx) begin
                    n_state = pli_pkg::S_EMIT;
                end else begin
                    n_state = pli_pkg::S_DIV;
                end
            end
            pli_pkg::S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = pli_pkg::S_FIN;
                end
            end
            pli_pkg::S_FIN:       n_state = pli_pkg::S_EMIT;
            pli_pkg::S_PAST_RD:   n_state = pli_pkg::S_PAST_WAIT;
            pli_pkg::S_PAST_WAIT: n_state = pli_pkg::S_EMIT;
            pli_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = pli_pkg::S_IDLE;
                end
            end
            default:              n_state = pli_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.asel  = pli_pkg::ASEL_SCAN;
        o_cmd.fin   = pli_pkg::FIN_NONE;
        o_req_stall = 1'b1;
        case (r_state)
            pli_pkg::S_IDLE: begin
                o_req_stall = 1'b0;
                if (i_req_valid) begin
                    o_cmd.start = (i_req_type == pli_pkg::REQ_QUERY);
                    o_cmd.wr    = (i_req_type == pli_pkg::REQ_WRITE);
                end
            end
            pli_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.n_zero) begin
                    o_cmd.fin = pli_pkg::FIN_EMPTY;
                end
            end
            pli_pkg::S_LD_HI: begin
                o_cmd.asel = pli_pkg::ASEL_HI;
            end
            pli_pkg::S_LD_LO: begin
                o_cmd.asel   = pli_pkg::ASEL_LO;
                o_cmd.cap_hi = 1'b1;
            end
            pli_pkg::S_CAP_LO: begin
                o_cmd.cap_lo = 1'b1;
            end
            pli_pkg::S_DIFF: begin
                o_cmd.diff = 1'b1;
            end
            pli_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_stat.eqx) begin
                    o_cmd.fin = pli_pkg::FIN_EQX;
                end
            end
            pli_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            pli_pkg::S_FIN: begin
                o_cmd.fin = pli_pkg::FIN_CALC;
            end
            pli_pkg::S_PAST_RD: begin
                o_cmd.asel = pli_pkg::ASEL_LAST;
            end
            pli_pkg::S_PAST_WAIT: begin
                o_cmd.fin = pli_pkg::FIN_PAST;
            end
            pli_pkg::S_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_req_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== design/pli_dp.sv =====
// datapath: breakpoint rams, scan counter, difference, multiply, serial divide, result
module pli_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pli_pkg::t_cmd  i_cmd,
    output pli_pkg::t_stat o_stat,
    input  pli_pkg::t_req  i_req,
    input  logic [8:0]     i_point_count,
    input  logic           i_res_stall,
    output logic           o_res_valid,
    output pli_pkg::t_res  o_res
);

    localparam int IW = pli_pkg::IDX_W;
    localparam int CW = pli_pkg::CNT_W;
    localparam int DW = pli_pkg::DATA_W;
    localparam int PW = pli_pkg::PROD_W;

    logic signed [DW-1:0] r_pos;
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_k;
    logic                 r_pend;
    logic [IW-1:0]        r_kf;
    logic signed [DW-1:0] r_x1;
    logic signed [DW-1:0] r_y1;
    logic signed [DW-1:0] r_x2;
    logic signed [DW-1:0] r_y2;
    logic [DW-1:0]        r_mdr;
    logic [DW-1:0]        r_mdy;
    logic [DW-1:0]        r_mdx;
    logic                 r_neg;
    logic                 r_eqx;
    logic [PW-1:0]        r_quo;
    logic [DW-1:0]        r_rem;
    logic [pli_pkg::DIVC_W-1:0] r_cnt;
    logic signed [DW-1:0] r_val;
    logic [2:0]           r_st;
    pli_pkg::t_res        r_res;
    logic                 r_res_valid;

    logic          wr_en;
    logic [IW-1:0] rd_addr;
    logic [DW-1:0] x_rd;
    logic [DW-1:0] y_rd;
    logic [CW-1:0] n_clamp;
    logic [CW-1:0] k_m1;
    logic [CW-1:0] n_m1;

    logic signed [DW:0] dr;
    logic signed [DW:0] dy;
    logic signed [DW:0] dx;
    logic signed [DW:0] ndr;
    logic signed [DW:0] ndy;
    logic signed [DW:0] ndx;
    logic [PW-1:0]      prod;

    logic [DW:0] rem_sh;
    logic        rem_ge;
    logic [DW:0] rem_sub;

    logic signed [DW+2:0] sum;
    logic signed [DW-1:0] calc_val;
    logic [2:0]           calc_st;

    assign wr_en = i_cmd.wr && (32'(i_req.point_index) < 32'(pli_pkg::MAX_POINTS));

    pli_ram #(.WIDTH(DW), .DEPTH(pli_pkg::MAX_POINTS)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (IW'(i_req.point_index)),
        .i_wdata (i_req.point_x),
        .i_raddr (rd_addr),
        .o_rdata (x_rd)
    );

    pli_ram #(.WIDTH(DW), .DEPTH(pli_pkg::MAX_POINTS)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (IW'(i_req.point_index)),
        .i_wdata (i_req.point_y),
        .i_raddr (rd_addr),
        .o_rdata (y_rd)
    );

    assign n_clamp = (32'(i_point_count) > 32'(pli_pkg::MAX_POINTS)) ?
                     CW'(pli_pkg::MAX_POINTS) : CW'(i_point_count);
    assign k_m1    = r_k - CW'(1);
    assign n_m1    = r_n - CW'(1);

    always_comb begin
        case (i_cmd.asel)
            pli_pkg::ASEL_SCAN: rd_addr = r_k[IW-1:0];
            pli_pkg::ASEL_HI:   rd_addr = r_kf;
            pli_pkg::ASEL_LO:   rd_addr = r_kf - IW'(1);
            pli_pkg::ASEL_LAST: rd_addr = n_m1[IW-1:0];
            default:            rd_addr = r_k[IW-1:0];
        endcase
    end

    assign o_stat.n_zero   = (r_n == '0);
    assign o_stat.more     = (r_k < r_n);
    assign o_stat.found    = r_pend && ($signed(x_rd) > r_pos);
    assign o_stat.eqx      = r_eqx;
    assign o_stat.div_last = (r_cnt == pli_pkg::DIVC_W'(pli_pkg::DIV_STEPS - 1));
    assign o_stat.out_free = !r_res_valid || !i_res_stall;

    // signed differences and their magnitudes
    assign dr  = {r_pos[DW-1], r_pos} - {r_x1[DW-1], r_x1};
    assign dy  = {r_y2[DW-1], r_y2} - {r_y1[DW-1], r_y1};
    assign dx  = {r_x2[DW-1], r_x2} - {r_x1[DW-1], r_x1};
    assign ndr = -dr;
    assign ndy = -dy;
    assign ndx = -dx;

    assign prod = r_mdr * r_mdy;

    // restoring divide, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_quo[PW-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_mdx});
    assign rem_sub = rem_sh - {1'b0, r_mdx};

    assign sum = r_neg ? ({{3{r_y1[DW-1]}}, r_y1} - $signed({2'b00, r_quo[DW:0]}))
                       : ({{3{r_y1[DW-1]}}, r_y1} + $signed({2'b00, r_quo[DW:0]}));

    always_comb begin
        if (|r_quo[PW-1:DW+1]) begin
            calc_val = r_neg ? pli_pkg::VAL_MIN : pli_pkg::VAL_MAX;
            calc_st  = pli_pkg::ST_SAT;
        end else if (sum > (DW+3)'(pli_pkg::VAL_MAX)) begin
            calc_val = pli_pkg::VAL_MAX;
            calc_st  = pli_pkg::ST_SAT;
        end else if (sum < (DW+3)'(pli_pkg::VAL_MIN)) begin
            calc_val = pli_pkg::VAL_MIN;
            calc_st  = pli_pkg::ST_SAT;
        end else begin
            calc_val = sum[DW-1:0];
            calc_st  = pli_pkg::ST_INTERP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.start) begin
            r_pend <= 1'b0;
        end else if (i_cmd.scan) begin
            r_pend <= (r_k < r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos <= i_req.query_position;
            r_n   <= n_clamp;
            r_k   <= CW'(1);
        end else if (i_cmd.scan && (r_k < r_n)) begin
            r_k <= r_k + CW'(1);
        end
        if (i_cmd.scan && o_stat.found) begin
            r_kf <= k_m1[IW-1:0];
        end
        if (i_cmd.cap_hi) begin
            r_x2 <= x_rd;
            r_y2 <= y_rd;
        end
        if (i_cmd.cap_lo) begin
            r_x1 <= x_rd;
            r_y1 <= y_rd;
        end
        if (i_cmd.diff) begin
            r_mdr <= dr[DW] ? ndr[DW-1:0] : dr[DW-1:0];
            r_mdy <= dy[DW] ? ndy[DW-1:0] : dy[DW-1:0];
            r_mdx <= dx[DW] ? ndx[DW-1:0] : dx[DW-1:0];
            r_neg <= dr[DW] ^ dy[DW] ^ dx[DW];
            r_eqx <= (r_x1 == r_x2);
        end
        if (i_cmd.mul) begin
            r_quo <= prod;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[PW-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_cnt <= r_cnt + pli_pkg::DIVC_W'(1);
        end
        case (i_cmd.fin)
            pli_pkg::FIN_EMPTY: begin
                r_val <= '0;
                r_st  <= pli_pkg::ST_EMPTY;
            end
            pli_pkg::FIN_PAST: begin
                r_val <= y_rd;
                r_st  <= pli_pkg::ST_PAST;
            end
            pli_pkg::FIN_EQX: begin
                r_val <= r_y1;
                r_st  <= pli_pkg::ST_EQUAL_X;
            end
            pli_pkg::FIN_CALC: begin
                r_val <= calc_val;
                r_st  <= calc_st;
            end
            default: begin
                r_val <= r_val;
                r_st  <= r_st;
            end
        endcase
        if (i_cmd.emit) begin
            r_res.interp_value <= r_val;
            r_res.status       <= r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== design/piecewise_linear_table_interp.sv =====
// top level: piecewise linear interpolation over a breakpoint table
//
//  channel   direction  handshake                 payload
//  request   in         i_req_valid / o_req_stall  i_req  (pli_pkg::t_req)
//  result    out        o_res_valid / i_res_stall  o_res  (pli_pkg::t_res)
//  config    in         apb psel/penable/pready    pwdata, point_count at 0x0
//
//  a write request does not stall the request side; a query's time grows with the
//  index of the interval found, through the linear scan over one ram read port
//  and the 64-step restoring divider; an empty or past-last query ends after the scan
//  synchronous active-low reset clears control state only, table contents stay undefined
//  a stalled result sits in the output register while the next query runs
module piecewise_linear_table_interp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_stall,
    input  pli_pkg::t_req                       i_req,
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output pli_pkg::t_res                       o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pli_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [pli_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [pli_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic [8:0]     r_point_count;
    logic           reg_sel;
    pli_pkg::t_cmd  cmd;
    pli_pkg::t_stat stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[pli_pkg::APB_ADDR_W-1:2] == pli_pkg::REG_POINT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_point_count <= pwdata[8:0];
        end
    end

    assign prdata = reg_sel ? pli_pkg::APB_DATA_W'(r_point_count) : '0;

    pli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_type  (i_req.req_type),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_req_stall (o_req_stall)
    );

    pli_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req         (i_req),
        .i_point_count (r_point_count),
        .i_res_stall   (i_res_stall),
        .o_res_valid   (o_res_valid),
        .o_res         (o_res)
    );

endmodule

// ===== design/pli_chk.sv =====
// port-level checker for the interpolator, bound to the top level
module pli_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           o_req_stall,
    input pli_pkg::t_req                  i_req,
    input logic                           o_res_valid,
    input logic                           i_res_stall,
    input pli_pkg::t_res                  o_res
);

    // a query keeps the request side busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall && i_req.req_type == pli_pkg::REQ_QUERY
        |=> o_req_stall)
        else $error("request side not busy after query");

    // a table write does not make the request side busy
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall && i_req.req_type == pli_pkg::REQ_WRITE
        |=> !o_req_stall)
        else $error("request side busy after table write");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_res))
        else $error("stalled result changed");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status == pli_pkg::ST_SAT
        |-> o_res.interp_value == pli_pkg::VAL_MAX || o_res.interp_value == pli_pkg::VAL_MIN)
        else $error("saturated result not at a bound");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status == pli_pkg::ST_EMPTY |-> o_res.interp_value == '0)
        else $error("empty table result not zero");

endmodule

bind piecewise_linear_table_interp pli_chk u_pli_chk (.*);
